@@ design/adts_pkg.sv @@
// ============================================================================
// ADTS deframer package
// Shared constants, parse mode type and transfer payload structs.
// ============================================================================
package adts_pkg;

    // Width of the buffer byte counter.
    localparam int LENGTH_BITS = 16;

    // Header layout constants.
    localparam logic [7:0] SYNC_BYTE       = 8'hFF;
    localparam logic [7:0] SYNC_NIBBLE     = 8'hF0;
    localparam logic [3:0] HDR_LEN_NO_CRC  = 4'd7;
    localparam logic [3:0] HDR_LEN_CRC     = 4'd9;
    localparam logic [3:0] RATE_IDX_LIMIT  = 4'd12;
    localparam logic [3:0] RATE_IDX_SUBST  = 4'd8;
    localparam logic [2:0] CHANNELS_MIN    = 3'd1;
    localparam logic [3:0] ASC_OBJECT_TYPE = 4'b0001;

    // Frame byte positions inside the header.
    localparam logic [12:0] POS_SYNC0   = 13'd0;
    localparam logic [12:0] POS_SYNC1   = 13'd1;
    localparam logic [12:0] POS_FIELD_F = 13'd2;
    localparam logic [12:0] POS_FIELD_L = 13'd4;
    localparam logic [12:0] POS_LENGTH  = 13'd5;

    typedef enum logic [1:0] {
        MODE_DISCARD = 2'd0,
        MODE_HEADER  = 2'd1,
        MODE_PAYLOAD = 2'd2
    } parse_mode_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        buffer_start;
        logic [15:0] buffer_length;
    } adts_in_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        frame_last;
        logic [1:0]  profile;
        logic [3:0]  rate_index;
        logic [2:0]  channel_count;
        logic [15:0] audio_config_word;
        logic [12:0] payload_length;
    } adts_out_t;

    // Decoded per-frame header fields, shared by the decoder and the top level.
    typedef struct packed {
        logic [1:0]  profile;
        logic [3:0]  rate_index;
        logic [2:0]  channel_count;
        logic [15:0] audio_config_word;
    } adts_hdr_t;

endpackage

@@ design/adts_hdr_decode.sv @@
// ============================================================================
// ADTS header field decoder
// Turns the stored header bytes 2..4 into profile, normalized rate index,
// channel count and the AudioSpecificConfig word.
// ============================================================================
module adts_hdr_decode
    import adts_pkg::*;
(
    input  logic [23:0] header_fields,
    input  logic [2:0]  default_channels,
    output adts_hdr_t   hdr
);

    logic [7:0] hf2;
    logic [7:0] hf3;
    logic [3:0] rate;
    logic [2:0] ch;

    assign hf2 = header_fields[23:16];
    assign hf3 = header_fields[15:8];

    always_comb begin
        rate = hf2[5:2];
        if (rate >= RATE_IDX_LIMIT) begin
            rate = RATE_IDX_SUBST;
        end
        ch = {hf2[0], hf3[7:6]};
        // A zero channel configuration falls back to the configured default,
        // and a zero default counts as a single channel.
        if (ch == 3'd0) begin
            ch = (default_channels == 3'd0) ? CHANNELS_MIN : default_channels;
        end
        hdr.profile           = hf2[7:6];
        hdr.rate_index        = rate;
        hdr.channel_count     = ch;
        hdr.audio_config_word = {ASC_OBJECT_TYPE, 1'b0, rate, 1'b0, ch, 3'b000};
    end

endmodule

@@ design/adts_aac_deframer_core.sv @@
// ============================================================================
// ADTS AAC deframer core
// Splits a byte stream of encoded-audio buffers into ADTS frames and passes
// the payload bytes on, tagged with the decoded header fields.
// ============================================================================
// Usage:
// The s_ channel takes one buffer byte per transfer. The first byte of each
// buffer carries buffer_start = 1 and the total buffer length. Header bytes
// (7, or 9 when a CRC is present) are consumed and produce no transfer; each
// payload byte produces exactly one m_ transfer carrying the byte, a
// frame_last mark and the frame's profile, rate index, channel count,
// AudioSpecificConfig and payload length. Bad sync, bad frame length and
// short tails drop the rest of the buffer until the next buffer_start.
// An accepted payload byte is registered and shown on m_ in the next cycle.
// Throughput is one byte per cycle while m_ready is high, set by the single
// result register; s_ready stays high while that register is empty or being
// drained, so a stalled receiver holds at most one result and back-pressures
// s_ only while it holds one. The user must write the default_channels
// register through cfg_wr_en/cfg_wr_data only while idle; the block does not
// enforce it. Synchronous active-low reset clears the parse state to discard
// mode, empties the result register and sets default_channels to one.
// ============================================================================
module adts_aac_deframer_core
    import adts_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  adts_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output adts_out_t m_data,
    input  logic      cfg_wr_en,
    input  logic [2:0] cfg_wr_data
);

    // Parse state.
    logic [LENGTH_BITS-1:0] bytes_rem_reg, bytes_rem_next;
    logic [12:0]            pos_reg, pos_next;
    logic [12:0]            frame_total_reg, frame_total_next;
    logic [3:0]             hdr_len_reg, hdr_len_next;
    logic [23:0]            hdr_fields_reg, hdr_fields_next;
    parse_mode_t            mode_reg, mode_next;
    logic [2:0]             def_ch_reg;

    // Result register.
    logic      m_valid_reg;
    adts_out_t m_data_reg, m_data_next;

    logic                   accept;
    logic                   emit;
    logic [31:0]            len_wide;
    logic [LENGTH_BITS-1:0] len_in;
    logic [LENGTH_BITS-1:0] bytes_cur;
    parse_mode_t            mode_cur;
    logic [12:0]            pos_cur;
    logic [13:0]            pos_inc;
    logic [12:0]            flen;
    logic [LENGTH_BITS:0]   avail;
    logic [7:0]             b;
    adts_hdr_t              hdr;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The buffer length is taken modulo the counter width.
    assign len_wide = {16'd0, s_data.buffer_length};
    assign len_in   = len_wide[LENGTH_BITS-1:0];
    assign b        = s_data.data_byte;

    // A buffer start restarts the counter and the frame at this very byte.
    assign bytes_cur = s_data.buffer_start ? len_in : bytes_rem_reg;
    assign mode_cur  = s_data.buffer_start ? MODE_HEADER : mode_reg;
    assign pos_cur   = s_data.buffer_start ? 13'd0 : pos_reg;
    assign pos_inc   = {1'b0, pos_cur} + 14'd1;
    assign flen      = {hdr_fields_reg[9:8], hdr_fields_reg[7:0], b[7:5]};
    // Bytes left at frame start: this byte, those after it, and bytes 0..4.
    assign avail     = {1'b0, bytes_cur} + (LENGTH_BITS+1)'(5);

    adts_hdr_decode u_hdr_decode (
        .header_fields    (hdr_fields_reg),
        .default_channels (def_ch_reg),
        .hdr              (hdr)
    );

    // Next-state logic for the parser.
    always_comb begin
        bytes_rem_next   = bytes_cur;
        pos_next         = pos_cur;
        frame_total_next = frame_total_reg;
        hdr_len_next     = hdr_len_reg;
        hdr_fields_next  = hdr_fields_reg;
        mode_next        = mode_cur;
        emit             = 1'b0;

        if (bytes_cur == '0 || mode_cur == MODE_DISCARD) begin
            mode_next = MODE_DISCARD;
            if (bytes_cur != '0) begin
                bytes_rem_next = bytes_cur - 1'b1;
            end
        end else begin
            bytes_rem_next = bytes_cur - 1'b1;
            case (mode_cur)
                MODE_HEADER: begin
                    pos_next = pos_inc[12:0];
                    if (pos_inc >= {10'd0, hdr_len_reg}) begin
                        mode_next = MODE_PAYLOAD;
                    end
                    if (pos_cur == POS_SYNC0) begin
                        // Short tail or missing sync byte.
                        if (bytes_cur < LENGTH_BITS'(7) || b != SYNC_BYTE) begin
                            mode_next = MODE_DISCARD;
                            pos_next  = pos_cur;
                        end
                    end else if (pos_cur == POS_SYNC1) begin
                        if ((b & SYNC_NIBBLE) != SYNC_NIBBLE) begin
                            mode_next = MODE_DISCARD;
                            pos_next  = pos_cur;
                        end else begin
                            hdr_len_next = b[0] ? HDR_LEN_NO_CRC : HDR_LEN_CRC;
                        end
                    end else if (pos_cur >= POS_FIELD_F && pos_cur <= POS_FIELD_L) begin
                        hdr_fields_next = {hdr_fields_reg[15:0], b};
                    end else if (pos_cur == POS_LENGTH) begin
                        if (flen <= {9'd0, hdr_len_reg}
                            || {{(LENGTH_BITS-12){1'b0}}, flen} > avail) begin
                            mode_next = MODE_DISCARD;
                            pos_next  = pos_cur;
                        end else begin
                            frame_total_next = flen;
                        end
                    end
                end
                MODE_PAYLOAD: begin
                    emit = 1'b1;
                    if (pos_inc >= {1'b0, frame_total_reg}) begin
                        pos_next  = 13'd0;
                        mode_next = MODE_HEADER;
                    end else begin
                        pos_next = pos_inc[12:0];
                    end
                end
                default: begin
                    mode_next = MODE_DISCARD;
                end
            endcase
        end
    end

    // Result fields for a payload byte.
    always_comb begin
        m_data_next.payload_byte      = b;
        m_data_next.frame_last        = (pos_inc >= {1'b0, frame_total_reg});
        m_data_next.profile           = hdr.profile;
        m_data_next.rate_index        = hdr.rate_index;
        m_data_next.channel_count     = hdr.channel_count;
        m_data_next.audio_config_word = hdr.audio_config_word;
        m_data_next.payload_length    = frame_total_reg - {9'd0, hdr_len_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_rem_reg   <= '0;
            pos_reg         <= '0;
            frame_total_reg <= '0;
            hdr_len_reg     <= HDR_LEN_NO_CRC;
            hdr_fields_reg  <= '0;
            mode_reg        <= MODE_DISCARD;
            def_ch_reg      <= CHANNELS_MIN;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                def_ch_reg <= cfg_wr_data;
            end
            if (accept) begin
                bytes_rem_reg   <= bytes_rem_next;
                pos_reg         <= pos_next;
                frame_total_reg <= frame_total_next;
                hdr_len_reg     <= hdr_len_next;
                hdr_fields_reg  <= hdr_fields_next;
                mode_reg        <= mode_next;
                m_valid_reg     <= emit;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // The result payload needs no reset; it is loaded with each accepted payload byte.
    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule
